// ===== src/ccw_pkg.sv =====
`default_nettype none

package ccw_pkg;

    localparam int unsigned SecMax   = 59;
    localparam int unsigned MinMax   = 59;
    localparam int unsigned HourMax  = 23;
    localparam int unsigned MonthMax = 12;
    localparam int unsigned YearMin  = 1;
    localparam int unsigned YearMax  = 9999;

    // floor(x / 25) = (x * Recip25) >> Recip25Shift for x below 2500
    localparam int unsigned Recip25      = 5243;
    localparam int unsigned Recip25Shift = 17;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_INC  = 2'd1,
        CMD_DEC  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        FLD_HOUR  = 3'd0,
        FLD_MIN   = 3'd1,
        FLD_DAY   = 3'd2,
        FLD_MONTH = 3'd3,
        FLD_YEAR  = 3'd4
    } t_field;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    function automatic logic f_is_leap(input logic [13:0] year);
        return (year[1:0] == 2'd0);
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // sakamoto month offsets, january first
    function automatic logic [2:0] f_dow_offset(input logic [3:0] month);
        logic [2:0] off;
        unique case (month)
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    // 8 = 1 mod 7, so octal digits are summed and folded
    function automatic logic [2:0] f_mod7(input logic [13:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]) + 5'(x[13:12]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/ccw_state.sv =====
`default_nettype none

module ccw_state (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [1:0]        i_command,
    input  wire [2:0]        i_field_select,
    output ccw_pkg::t_time   o_time,
    output logic             o_valid,
    input  wire              i_ready
);
    import ccw_pkg::*;

    t_time      r_time;
    t_time      n_time;
    t_time      r_snap;
    logic       r_valid;
    logic       accept;
    t_cmd       cmd;
    t_field     fld;
    logic [4:0] len_cur;
    logic [3:0] month_adj;
    logic [13:0] year_adj;
    logic [4:0] len_month_adj;
    logic [4:0] len_year_adj;
    logic       up;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign cmd     = t_cmd'(i_command);
    assign fld     = t_field'(i_field_select);
    assign up      = (cmd == CMD_INC);

    assign len_cur = f_month_len(r_time.month, f_is_leap(r_time.year));

    always_comb begin
        if (up) begin
            month_adj = (r_time.month >= 4'(MonthMax)) ? 4'd1 : r_time.month + 4'd1;
            year_adj  = (r_time.year < 14'(YearMax)) ? r_time.year + 14'd1 : r_time.year;
        end else begin
            month_adj = (r_time.month <= 4'd1) ? 4'(MonthMax) : r_time.month - 4'd1;
            year_adj  = (r_time.year > 14'(YearMin)) ? r_time.year - 14'd1 : r_time.year;
        end
    end

    assign len_month_adj = f_month_len(month_adj, f_is_leap(r_time.year));
    assign len_year_adj  = f_month_len(r_time.month, f_is_leap(year_adj));

    always_comb begin
        n_time = r_time;
        unique case (cmd)
            CMD_TICK: begin
                if (r_time.second >= 6'(SecMax)) begin
                    n_time.second = 6'd0;
                    if (r_time.minute >= 6'(MinMax)) begin
                        n_time.minute = 6'd0;
                        if (r_time.hour >= 5'(HourMax)) begin
                            n_time.hour = 5'd0;
                            if (r_time.day >= len_cur) begin
                                n_time.day = 5'd1;
                                if (r_time.month >= 4'(MonthMax)) begin
                                    n_time.month = 4'd1;
                                    if (r_time.year < 14'(YearMax)) begin
                                        n_time.year = r_time.year + 14'd1;
                                    end
                                end else begin
                                    n_time.month = r_time.month + 4'd1;
                                end
                            end else begin
                                n_time.day = r_time.day + 5'd1;
                            end
                        end else begin
                            n_time.hour = r_time.hour + 5'd1;
                        end
                    end else begin
                        n_time.minute = r_time.minute + 6'd1;
                    end
                end else begin
                    n_time.second = r_time.second + 6'd1;
                end
            end
            CMD_INC, CMD_DEC: begin
                unique case (fld)
                    FLD_HOUR: begin
                        if (up) begin
                            n_time.hour = (r_time.hour >= 5'(HourMax)) ? 5'd0
                                                                       : r_time.hour + 5'd1;
                        end else begin
                            n_time.hour = (r_time.hour == 5'd0) ? 5'(HourMax)
                                                                : r_time.hour - 5'd1;
                        end
                        n_time.second = 6'd0;
                    end
                    FLD_MIN: begin
                        if (up) begin
                            n_time.minute = (r_time.minute >= 6'(MinMax)) ? 6'd0
                                                                          : r_time.minute + 6'd1;
                        end else begin
                            n_time.minute = (r_time.minute == 6'd0) ? 6'(MinMax)
                                                                    : r_time.minute - 6'd1;
                        end
                        n_time.second = 6'd0;
                    end
                    FLD_DAY: begin
                        if (up) begin
                            n_time.day = (r_time.day >= len_cur) ? 5'd1 : r_time.day + 5'd1;
                        end else begin
                            n_time.day = (r_time.day <= 5'd1) ? len_cur : r_time.day - 5'd1;
                        end
                    end
                    FLD_MONTH: begin
                        n_time.month = month_adj;
                        if (r_time.day > len_month_adj) begin
                            n_time.day = len_month_adj;
                        end
                    end
                    FLD_YEAR: begin
                        n_time.year = year_adj;
                        if (r_time.day > len_year_adj) begin
                            n_time.day = len_year_adj;
                        end
                    end
                    default: begin
                        n_time = r_time;
                    end
                endcase
            end
            CMD_NONE: begin
                n_time = r_time;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.second <= 6'd0;
            r_time.minute <= 6'd0;
            r_time.hour   <= 5'd0;
            r_time.day    <= 5'd1;
            r_time.month  <= 4'd1;
            r_time.year   <= 14'd2000;
            r_valid       <= 1'b0;
        end else begin
            if (accept) begin
                r_time <= n_time;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_snap <= n_time;
        end
    end

    assign o_time  = r_snap;
    assign o_valid = r_valid;

`ifndef SYNTH
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_time.second <= 6'(SecMax)) && (r_time.minute <= 6'(MinMax))
        && (r_time.hour <= 5'(HourMax)))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_time.month >= 4'd1) && (r_time.month <= 4'(MonthMax))
        && (r_time.year >= 14'(YearMin)) && (r_time.year <= 14'(YearMax))
        && (r_time.day >= 5'd1) && (r_time.day <= len_cur))
        else $error("date out of range");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_time))
        else $error("clock state changed without a request");
`endif

endmodule

`default_nettype wire

// ===== src/ccw_weekday.sv =====
`default_nettype none

module ccw_weekday (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire ccw_pkg::t_time i_time,
    output logic             o_valid,
    input  wire              i_ready,
    output ccw_pkg::t_time   o_time,
    output logic [2:0]       o_weekday
);
    import ccw_pkg::*;

    // stage a: shifted year and its hundreds
    logic [13:0] year_adj;
    logic [11:0] q4_in;
    logic [24:0] prod;
    logic        ready_a;
    logic        ready_b;

    logic        r_valid_a;
    t_time       r_time_a;
    logic [13:0] r_year_a;
    logic [6:0]  r_q100_a;
    logic [5:0]  r_offday_a;

    // stage b: sum and fold
    logic [13:0] sum;

    logic        r_valid_b;
    t_time       r_time_b;
    logic [2:0]  r_wday_b;

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;

    assign year_adj = i_time.year - 14'(i_time.month < 4'd3);
    assign q4_in    = year_adj[13:2];
    assign prod     = 25'(q4_in) * 25'(Recip25);

    assign sum = r_year_a + 14'(r_year_a[13:2]) + 14'(r_q100_a[6:2])
               - 14'(r_q100_a) + 14'(r_offday_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_time_a   <= i_time;
            r_year_a   <= year_adj;
            r_q100_a   <= prod[Recip25Shift +: 7];
            r_offday_a <= 6'(f_dow_offset(i_time.month)) + 6'(i_time.day);
        end
        if (ready_b && r_valid_a) begin
            r_time_b <= r_time_a;
            r_wday_b <= f_mod7(sum);
        end
    end

    assign o_valid   = r_valid_b;
    assign o_time    = r_time_b;
    assign o_weekday = r_wday_b;

`ifndef SYNTH
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_b |-> (r_wday_b <= 3'd6))
        else $error("weekday out of range");

    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid_a && !ready_b) |=> (r_valid_a && $stable(r_year_a) && $stable(r_q100_a)))
        else $error("middle stage lost data under stall");

    a_hundreds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_a |-> (r_q100_a <= 7'd99))
        else $error("year hundreds out of range");
`endif

endmodule

`default_nettype wire

// ===== src/calendar_clock_with_weekday_unit.sv =====
// calendar clock with weekday
//
// slave channel carries one request per transfer: tdata[1:0] is the command
// (tick, increment, decrement or none), tuser[2:0] selects the field to adjust
// (hour, minute, day, month, year). the clock state is updated in the
// cycle the request is taken, so a request may arrive on every clock while tready is high.
// master channel returns one result per request with the full time, date
// and weekday as they stand after that request.
// the result passes through the state snapshot register (state update), then
// the year hundreds multiply and the weekday sum and fold registers.
// throughput: one request per cycle while the master side does not stall.
// reset (synchronous, active low) sets 00:00:00 on 2000-01-01 and empties
// the pipeline. when the receiver stalls, each stage holds its data and
// keeps taking requests until all three registers are full; tready on the
// slave side then drops until the master side moves again.
`default_nettype none

module calendar_clock_with_weekday_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // command[1:0], zero pad[7:2]
    input  wire  [2:0]  i_s_axis_tuser,   // field_select[2:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // second_now[5:0], minute_now[11:6],
                                          // hour_now[16:12], day_now[21:17],
                                          // month_now[25:22], year_now[39:26],
                                          // weekday[42:40], zero pad[47:43]
);
    import ccw_pkg::*;

    t_time      snap_time;
    logic       snap_valid;
    logic       snap_ready;
    t_time      res_time;
    logic [2:0] res_wday;

    // clock state and snapshot of each updated time
    ccw_state u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_command      (i_s_axis_tdata[1:0]),
        .i_field_select (i_s_axis_tuser),
        .o_time         (snap_time),
        .o_valid        (snap_valid),
        .i_ready        (snap_ready)
    );

    // weekday pipeline with the output register at its end
    ccw_weekday u_weekday (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (snap_valid),
        .o_ready   (snap_ready),
        .i_time    (snap_time),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_time    (res_time),
        .o_weekday (res_wday)
    );

    // pack result fields, lowest first
    assign o_m_axis_tdata = {5'd0, res_wday, res_time.year, res_time.month, res_time.day,
                             res_time.hour, res_time.minute, res_time.second};

endmodule

`default_nettype wire
